>>> src/snkt_pkg.sv
// shared types and constants for the sorted node key table
package snkt_pkg;

   localparam int CAPACITY = 8;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 31;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 3;
   localparam int FUNC_W   = 2;
   localparam int STAT_W   = 2;
   localparam int RIDX_W   = 4;
   localparam int ECNT_W   = 4;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 48;

   localparam int REQ_KEY_LSB   = 0;
   localparam int REQ_VAL_LSB   = REQ_KEY_LSB + KEY_W;
   localparam int REQ_POS_LSB   = REQ_VAL_LSB + VAL_W;
   localparam int REQ_USED_W    = REQ_POS_LSB + POS_W;

   localparam int RSP_IDX_LSB   = 0;
   localparam int RSP_VAL_LSB   = RSP_IDX_LSB + RIDX_W;
   localparam int RSP_CNT_LSB   = RSP_VAL_LSB + VAL_W;
   localparam int RSP_FULL_BIT  = RSP_CNT_LSB + ECNT_W;
   localparam int RSP_USED_W    = RSP_FULL_BIT + 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_ROUTE  = 2'd1,
      FUNC_FIND   = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_BAD_INDEX = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIND,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } store_wr_type;

endpackage

>>> src/snkt_store.sv
// key and value entry store with one write port and one read port
module snkt_store (
   input  logic                        clock,
   input  snkt_pkg::store_wr_type      wr,
   input  logic [snkt_pkg::IDX_W-1:0]  rd_idx,
   output logic [snkt_pkg::KEY_W-1:0]  rd_key,
   output logic [snkt_pkg::VAL_W-1:0]  rd_value
);
   import snkt_pkg::*;

   logic [KEY_W-1:0] key_mem_ff [CAPACITY];
   logic [VAL_W-1:0] val_mem_ff [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem_ff[wr.idx] <= wr.key;
         val_mem_ff[wr.idx] <= wr.value;
      end
   end

   assign rd_key   = key_mem_ff[rd_idx];
   assign rd_value = val_mem_ff[rd_idx];

endmodule

>>> src/sorted_node_key_table.sv
// sorted node key table: one b-tree node with insert, route, find and remove-at
//
// Usage:
//   req_ channel carries one operation per transaction; req_tuser holds the
//   operation code, req_tdata the key, value and position.
//   rsp_ channel returns exactly one result per operation; rsp_tuser holds the
//   status, rsp_tdata the index, found value, entry count and full flag.
//   Key compares and one store read port are stepped over the entries, one
//   entry per cycle, under a small sequencer. An insert scans for its slot,
//   shifts the later entries up and writes the new entry; a route or find
//   scans the entries; a remove shifts the later entries down from the
//   position. Rejected operations go straight to the result. Only one
//   operation is in flight; req_tready is low meanwhile and rises together
//   with rsp_tvalid when the result enters the output register.
//   The result sits in an output register, so the next operation may be
//   accepted while it waits; if the receiver stalls with rsp_tready low, the
//   following operation finishes its work and then waits for that register.
//   Synchronous reset empties the table (entry count zero) and drops any
//   pending result; the store contents themselves are not cleared.
module sorted_node_key_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // key, value, position
   input  logic [snkt_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [snkt_pkg::FUNC_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_index, found_value, entry_count, table_full
   output logic [snkt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [snkt_pkg::STAT_W-1:0]     rsp_tuser
);
   import snkt_pkg::*;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  slot_ff, slot_in;
   status_type        res_status_ff, res_status_in;
   logic [RIDX_W-1:0] res_index_ff, res_index_in;
   logic [VAL_W-1:0]  res_value_ff, res_value_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [RIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ECNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_full_ff, rsp_full_in;

   store_wr_type      wr;
   logic [IDX_W-1:0]  rd_idx;
   logic [KEY_W-1:0]  rd_key;
   logic [VAL_W-1:0]  rd_value;

   logic              req_fire;
   func_type          req_func;
   logic [KEY_W-1:0]  req_key;
   logic [VAL_W-1:0]  req_value;
   logic [CNT_W-1:0]  req_pos;
   logic [CNT_W-1:0]  idx_next;

   snkt_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_idx   (rd_idx),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_func   = func_type'(req_tuser);
   assign req_key    = req_tdata[REQ_KEY_LSB +: KEY_W];
   assign req_value  = req_tdata[REQ_VAL_LSB +: VAL_W];
   assign req_pos    = CNT_W'(req_tdata[REQ_POS_LSB +: POS_W]);
   assign idx_next   = idx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_full_ff   <= rsp_full_in;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_full_in   = rsp_full_ff;
      rd_idx        = idx_ff[IDX_W-1:0];
      wr            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in       = req_func;
               key_in        = req_key;
               val_in        = req_value;
               idx_in        = '0;
               res_index_in  = '0;
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               case (req_func)
                  FUNC_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = STATUS_FULL;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_ROUTE: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_FIND: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NOT_FOUND;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_FIND;
                     end
                  end
                  default: begin
                     if (req_pos >= count_ff) begin
                        res_status_in = STATUS_BAD_INDEX;
                        state_in      = ST_DONE;
                     end else begin
                        idx_in   = req_pos;
                        state_in = ST_SHIFT_DOWN;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff < count_ff && rd_key <= key_ff) begin
               idx_in = idx_next;
            end else if (func_ff == FUNC_INSERT) begin
               slot_in  = idx_ff;
               idx_in   = count_ff;
               state_in = ST_SHIFT_UP;
            end else begin
               res_index_in = RIDX_W'(idx_ff);
               state_in     = ST_DONE;
            end
         end
         ST_SHIFT_UP: begin
            if (idx_ff > slot_ff) begin
               rd_idx   = IDX_W'(idx_ff - CNT_W'(1));
               wr.en    = 1'b1;
               wr.idx   = idx_ff[IDX_W-1:0];
               wr.key   = rd_key;
               wr.value = rd_value;
               idx_in   = idx_ff - CNT_W'(1);
            end else begin
               wr.en        = 1'b1;
               wr.idx       = slot_ff[IDX_W-1:0];
               wr.key       = key_ff;
               wr.value     = val_ff;
               count_in     = count_ff + CNT_W'(1);
               res_index_in = RIDX_W'(slot_ff + CNT_W'(1));
               state_in     = ST_DONE;
            end
         end
         ST_FIND: begin
            if (idx_ff >= count_ff) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_DONE;
            end else if (rd_key == key_ff) begin
               res_index_in = RIDX_W'(idx_ff);
               res_value_in = rd_value;
               state_in     = ST_DONE;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_SHIFT_DOWN: begin
            if (idx_next < count_ff) begin
               rd_idx   = idx_next[IDX_W-1:0];
               wr.en    = 1'b1;
               wr.idx   = idx_ff[IDX_W-1:0];
               wr.key   = rd_key;
               wr.value = rd_value;
               idx_in   = idx_next;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = ECNT_W'(count_ff);
               rsp_full_in   = (count_ff == CNT_W'(CAPACITY));
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_USED_W){1'b0}}, rsp_full_ff, rsp_count_ff,
                        rsp_value_ff, rsp_index_ff};

endmodule

>>> src/snkt_checker.sv
// port-level checks for the sorted node key table, bound to the top level
module snkt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [snkt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [snkt_pkg::STAT_W-1:0]     rsp_tuser
);
   import snkt_pkg::*;

   logic [ECNT_W-1:0] rsp_count;
   logic [RIDX_W-1:0] rsp_index;
   logic              rsp_full;

   assign rsp_count = rsp_tdata[RSP_CNT_LSB +: ECNT_W];
   assign rsp_index = rsp_tdata[RSP_IDX_LSB +: RIDX_W];
   assign rsp_full  = rsp_tdata[RSP_FULL_BIT];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_full == (rsp_count == ECNT_W'(CAPACITY)))
                     && (rsp_count <= ECNT_W'(CAPACITY)))
      else $error("full flag disagrees with entry count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_FULL |-> rsp_full && rsp_index == '0)
      else $error("full status on a table that is not full");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("operation accepted in back-to-back cycles");

endmodule

bind sorted_node_key_table snkt_checker u_snkt_checker (.*);
